>>> src/dpf_pkg.sv
// Shared types, constants and helpers for the duplicate packet filter.
`timescale 1ns / 1ps
package dpf_pkg;

    localparam int DEPTH   = 32;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ENTRY_W = 16 + 32 + 32;
    localparam int CIDX_W  = 8;

    localparam logic [5:0]  MAX_ENTRIES_RST = 6'd32;
    localparam logic [31:0] RETENTION_RST   = 32'd300000;
    localparam logic [31:0] INTERVAL_RST    = 32'd30000;
    localparam logic        AUTO_RST        = 1'b1;

    localparam logic [CIDX_W-1:0] REG_MAX_ENTRIES = 8'd0;
    localparam logic [CIDX_W-1:0] REG_RETENTION   = 8'd1;
    localparam logic [CIDX_W-1:0] REG_INTERVAL    = 8'd2;
    localparam logic [CIDX_W-1:0] REG_AUTO        = 8'd3;

    typedef enum logic [2:0] {
        OP_CHECK  = 3'd0,
        OP_RECORD = 3'd1,
        OP_TICK   = 3'd2,
        OP_PURGE  = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic scan_need;
        logic scan_done;
        logic out_free;
    } status_t;

    // cap saturated into 1..DEPTH
    function automatic logic [CNT_W-1:0] eff_cap(input logic [5:0] v);
        logic [CNT_W-1:0] c;
        if (v == 6'd0)
            c = CNT_W'(1);
        else if (32'(v) > DEPTH)
            c = CNT_W'(DEPTH);
        else
            c = CNT_W'(v);
        return c;
    endfunction

endpackage

>>> src/dpf_in_if.sv
// Input item channel.
`timescale 1ns / 1ps
interface dpf_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [15:0] source_id;
    logic [31:0] packet_id;
    logic [31:0] max_age_ms;

    modport source (output valid, op, source_id, packet_id, max_age_ms, input ready);
    modport sink (input valid, op, source_id, packet_id, max_age_ms, output ready);
endinterface

>>> src/dpf_out_if.sv
// Result item channel.
`timescale 1ns / 1ps
interface dpf_out_if;
    logic        valid;
    logic        ready;
    logic        seen;
    logic [5:0]  entry_count;
    logic        is_full;
    logic [31:0] checks_total;
    logic [31:0] duplicates_total;

    modport source (output valid, seen, entry_count, is_full, checks_total,
                    duplicates_total, input ready);
    modport sink (input valid, seen, entry_count, is_full, checks_total,
                  duplicates_total, output ready);
endinterface

>>> src/dpf_cfg_if.sv
// Configuration write channel.
`timescale 1ns / 1ps
interface dpf_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> src/dpf_ram.sv
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps
module dpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> src/dpf_ctrl.sv
// Sequencer: accepts an item, runs the table scan when the op needs one, commits the result.
`timescale 1ns / 1ps
module dpf_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  dpf_pkg::status_t status,
    output dpf_pkg::cmd_t    cmd
);
    import dpf_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = status.scan_need ? ST_SCAN : ST_FINISH;
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_SCAN:   cmd.step   = !status.scan_done;
            ST_FINISH: cmd.commit = status.out_free;
            default:   cmd        = '0;
        endcase
    end

`ifndef SYNTHESIS
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == ST_IDLE) else $error("load outside idle");
    a_commit_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> state_reg == ST_IDLE) else $error("commit did not return to idle");
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.step, cmd.commit})) else $error("overlapping commands");
`endif

endmodule

>>> src/dpf_dp.sv
// Datapath: ring-ordered entry table, counters, clock and result register.
`timescale 1ns / 1ps
module dpf_dp (
    input  logic             clk,
    input  logic             rst_n,
    input  dpf_pkg::cmd_t    cmd,
    output dpf_pkg::status_t status,
    input  logic [2:0]       in_op,
    input  logic [15:0]      in_source_id,
    input  logic [31:0]      in_packet_id,
    input  logic [31:0]      in_max_age_ms,
    input  logic             cfg_valid,
    input  logic [7:0]       cfg_index,
    input  logic [31:0]      cfg_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             out_seen,
    output logic [5:0]       out_entry_count,
    output logic             out_is_full,
    output logic [31:0]      out_checks_total,
    output logic [31:0]      out_duplicates_total
);
    import dpf_pkg::*;

    // configuration
    logic [5:0]  max_ent_reg, max_ent_next;
    logic [31:0] ret_reg, ret_next;
    logic [31:0] intv_reg, intv_next;
    logic        auto_reg, auto_next;
    // table and block state
    logic [PTR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0] now_reg, now_next;
    logic [31:0] last_reg, last_next;
    logic [31:0] checks_reg, checks_next;
    logic [31:0] dups_reg, dups_next;
    // current item
    op_t         op_reg, op_next;
    logic [15:0] src_reg, src_next;
    logic [31:0] pid_reg, pid_next;
    logic [31:0] limit_reg, limit_next;
    logic        purge_reg, purge_next;
    logic        hit_reg, hit_next;
    // scan
    logic [CNT_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic [CNT_W-1:0] wr_cnt_reg, wr_cnt_next;
    logic        rd_vld_reg, rd_vld_next;
    // result
    logic        ovalid_reg, ovalid_next;
    logic        oseen_reg, oseen_next;
    logic [5:0]  ocount_reg, ocount_next;
    logic        ofull_reg, ofull_next;
    logic [31:0] ochecks_reg, ochecks_next;
    logic [31:0] odups_reg, odups_next;

    logic               wr_en, rd_en;
    logic [PTR_W-1:0]   wr_addr, rd_addr;
    logic [ENTRY_W-1:0] wr_data, rd_data;
    logic [15:0]        e_src;
    logic [31:0]        e_pid, e_stamp;
    logic               tick_clean;
    logic [CNT_W-1:0]   cap, cfg_cap, keep_cnt;
    op_t                in_op_e;

    dpf_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_op_e = op_t'(in_op);
    assign {e_src, e_pid, e_stamp} = rd_data;
    assign cap        = eff_cap(max_ent_reg);
    assign cfg_cap    = eff_cap(cfg_data[5:0]);
    assign tick_clean = auto_reg && (32'(now_reg + 32'd1 - last_reg) >= intv_reg);

    assign status.scan_need = (in_op_e == OP_CHECK) || (in_op_e == OP_PURGE) ||
                              ((in_op_e == OP_TICK) && tick_clean);
    assign status.scan_done = (rd_cnt_reg == count_reg) && !rd_vld_reg;
    assign status.out_free  = !ovalid_reg || out_ready;

    always_comb
    begin
        max_ent_next = max_ent_reg;
        ret_next     = ret_reg;
        intv_next    = intv_reg;
        auto_next    = auto_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        now_next     = now_reg;
        last_next    = last_reg;
        checks_next  = checks_reg;
        dups_next    = dups_reg;
        op_next      = op_reg;
        src_next     = src_reg;
        pid_next     = pid_reg;
        limit_next   = limit_reg;
        purge_next   = purge_reg;
        hit_next     = hit_reg;
        rd_cnt_next  = rd_cnt_reg;
        wr_cnt_next  = wr_cnt_reg;
        rd_vld_next  = 1'b0;
        ovalid_next  = ovalid_reg && !out_ready;
        oseen_next   = oseen_reg;
        ocount_next  = ocount_reg;
        ofull_next   = ofull_reg;
        ochecks_next = ochecks_reg;
        odups_next   = odups_reg;
        wr_en        = 1'b0;
        wr_addr      = head_reg + wr_cnt_reg[PTR_W-1:0];
        wr_data      = {e_src, e_pid, e_stamp};
        rd_en        = 1'b0;
        rd_addr      = head_reg + rd_cnt_reg[PTR_W-1:0];
        keep_cnt     = count_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_MAX_ENTRIES:
                begin
                    max_ent_next = cfg_data[5:0];
                    if (count_reg > cfg_cap)
                    begin
                        head_next  = head_reg + PTR_W'(count_reg - cfg_cap);
                        count_next = cfg_cap;
                    end
                end
                REG_RETENTION: ret_next  = cfg_data;
                REG_INTERVAL:  intv_next = cfg_data;
                REG_AUTO:      auto_next = cfg_data[0];
                default: ;
            endcase
        end

        if (cmd.load)
        begin
            op_next     = in_op_e;
            src_next    = in_source_id;
            pid_next    = in_packet_id;
            hit_next    = 1'b0;
            rd_cnt_next = '0;
            wr_cnt_next = '0;
            purge_next  = (in_op_e == OP_PURGE) || ((in_op_e == OP_TICK) && tick_clean);
            limit_next  = (in_op_e == OP_TICK) ? ret_reg : in_max_age_ms;
            if (in_op_e == OP_TICK)
                now_next = now_reg + 32'd1;
        end

        if (cmd.step)
        begin
            if (rd_cnt_reg < count_reg)
            begin
                rd_en       = 1'b1;
                rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                rd_vld_next = 1'b1;
            end
            if (rd_vld_reg)
            begin
                if (purge_reg)
                begin
                    // kept entries slide down in place, order preserved
                    if (32'(now_reg - e_stamp) <= limit_reg)
                    begin
                        wr_en       = 1'b1;
                        wr_cnt_next = wr_cnt_reg + CNT_W'(1);
                    end
                end
                else if (e_src == src_reg && e_pid == pid_reg)
                begin
                    hit_next = 1'b1;
                end
            end
        end

        if (cmd.commit)
        begin
            case (op_reg)
                OP_CHECK:
                begin
                    checks_next = checks_reg + 32'd1;
                    dups_next   = dups_reg + 32'(hit_reg);
                end
                OP_RECORD:
                begin
                    if (pid_reg != 32'd0)
                    begin
                        if (count_reg >= cap)
                        begin
                            keep_cnt  = cap - CNT_W'(1);
                            head_next = head_reg + PTR_W'(count_reg - keep_cnt);
                        end
                        wr_en      = 1'b1;
                        wr_addr    = head_next + keep_cnt[PTR_W-1:0];
                        wr_data    = {src_reg, pid_reg, now_reg};
                        count_next = keep_cnt + CNT_W'(1);
                    end
                end
                OP_TICK, OP_PURGE:
                begin
                    if (purge_reg)
                    begin
                        count_next = wr_cnt_reg;
                        last_next  = now_reg;
                    end
                end
                OP_CLEAR: count_next = '0;
                default: ;
            endcase
            ovalid_next  = 1'b1;
            oseen_next   = (op_reg == OP_CHECK) && hit_reg;
            ocount_next  = 6'(count_next);
            ofull_next   = count_next >= cap;
            ochecks_next = checks_next;
            odups_next   = dups_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_ent_reg <= MAX_ENTRIES_RST;
            ret_reg     <= RETENTION_RST;
            intv_reg    <= INTERVAL_RST;
            auto_reg    <= AUTO_RST;
            head_reg    <= '0;
            count_reg   <= '0;
            now_reg     <= '0;
            last_reg    <= '0;
            checks_reg  <= '0;
            dups_reg    <= '0;
            rd_cnt_reg  <= '0;
            wr_cnt_reg  <= '0;
            rd_vld_reg  <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            max_ent_reg <= max_ent_next;
            ret_reg     <= ret_next;
            intv_reg    <= intv_next;
            auto_reg    <= auto_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            now_reg     <= now_next;
            last_reg    <= last_next;
            checks_reg  <= checks_next;
            dups_reg    <= dups_next;
            rd_cnt_reg  <= rd_cnt_next;
            wr_cnt_reg  <= wr_cnt_next;
            rd_vld_reg  <= rd_vld_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        src_reg     <= src_next;
        pid_reg     <= pid_next;
        limit_reg   <= limit_next;
        purge_reg   <= purge_next;
        hit_reg     <= hit_next;
        oseen_reg   <= oseen_next;
        ocount_reg  <= ocount_next;
        ofull_reg   <= ofull_next;
        ochecks_reg <= ochecks_next;
        odups_reg   <= odups_next;
    end

    assign out_valid            = ovalid_reg;
    assign out_seen             = oseen_reg;
    assign out_entry_count      = ocount_reg;
    assign out_is_full          = ofull_reg;
    assign out_checks_total     = ochecks_reg;
    assign out_duplicates_total = odups_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH)) else $error("entry count above depth");
    a_write_behind_read: assert property (@(posedge clk) disable iff (!rst_n)
        wr_cnt_reg <= rd_cnt_reg) else $error("compaction write passed read");
    a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> rd_cnt_reg <= count_reg) else $error("scan read past count");
    a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> ovalid_reg) else $error("commit produced no result");
`endif

endmodule

>>> src/duplicate_packet_filter_top.sv
// Duplicate packet filter: table of recently seen (source, packet id) pairs.
//
// Channels: din carries one op item (check, record, tick, purge, clear);
// dout returns one status result per item; cfg writes the four setup
// registers (cap, retention, cleanup interval, auto cleanup) and is always
// ready. The user must write configuration only while no item is in flight
// (not enforced). Each transfer happens when valid and ready are both high.
//
// Record, clear, unused ops and tick without cleanup skip the scan and go
// straight to the commit step. Check, purge and a cleanup tick walk the
// stored entries through the table RAM's single read port, one entry per
// cycle, before the commit. One item is in flight at a time, so din takes
// no new item until the current one has left the commit step.
// The result sits in an output register; din is ready again while it waits,
// and a finished item holds in the commit step until dout frees.
// Reset empties the table, zeroes the clock and counters and loads the
// register defaults; no clearing pass is needed.
`timescale 1ns / 1ps
module duplicate_packet_filter_top (
    input  logic       clk,
    input  logic       rst_n,
    dpf_in_if.sink     din,
    dpf_out_if.source  dout,
    dpf_cfg_if.sink    cfg
);
    import dpf_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg.ready = 1'b1;

    dpf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (din.valid),
        .in_ready (din.ready),
        .status   (status),
        .cmd      (cmd)
    );

    dpf_dp u_dp (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .status               (status),
        .in_op                (din.op),
        .in_source_id         (din.source_id),
        .in_packet_id         (din.packet_id),
        .in_max_age_ms        (din.max_age_ms),
        .cfg_valid            (cfg.valid),
        .cfg_index            (cfg.index),
        .cfg_data             (cfg.data),
        .out_valid            (dout.valid),
        .out_ready            (dout.ready),
        .out_seen             (dout.seen),
        .out_entry_count      (dout.entry_count),
        .out_is_full          (dout.is_full),
        .out_checks_total     (dout.checks_total),
        .out_duplicates_total (dout.duplicates_total)
    );

endmodule
